// ----- hdl/rgb2hsl_pkg.sv -----
// constants and widths shared by the rgb to hsl conversion pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rgb2hsl_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned HUE_W   = 15;
  localparam int unsigned PCT_W   = 13;
  localparam int unsigned HNUM_W  = 11;
  localparam int unsigned SUM_W   = 9;
  localparam int unsigned DEN2_W  = 9;

  // numerator widths of the three quotients
  localparam int unsigned NH_W    = 24;
  localparam int unsigned NS_W    = 22;
  localparam int unsigned NL_W    = 23;

  // reciprocal scaling, quotient estimate is (n * rcp) >> RCP_SHIFT
  localparam int unsigned RCP_SHIFT = 24;
  localparam int unsigned RCP_W     = 24;
  localparam int unsigned RCP_DEPTH = 256;

  // rounding is floor((2*x*scale + den) / (2*den))
  localparam logic [12:0] HUE_SCALE2 = 13'd7680;
  localparam logic [13:0] PCT_SCALE2 = 14'd12800;

  // lightness divides by 2*510
  localparam logic [10:0] LIT_DEN2   = 11'd1020;
  localparam logic [8:0]  LIT_HALF   = 9'd510;
  localparam int unsigned LIT_RCP_W  = 15;
  localparam logic [LIT_RCP_W-1:0] LIT_RCP = LIT_RCP_W'((32'd1 << RCP_SHIFT) / 32'd1020);

  localparam logic [HUE_W-1:0] HUE_LIMIT = 15'd23040;
  localparam logic [PCT_W-1:0] PCT_MAX   = 13'd6400;

endpackage

`default_nettype wire

// ----- hdl/rgb_to_hsl_converter.sv -----
// rgb to hsl conversion, five register stages with per-stage valid bits
// depends on rgb2hsl_pkg
`timescale 1ns / 1ps
`default_nettype none

// Converts one 8-bit rgb pixel per beat into hue (1/64 degree), saturation and
// lightness (1/64 percent), rounded to nearest with halves up. A pixel accepted
// into the first stage register moves through the later stage registers to the
// result register; one pixel enters per cycle while the output is not stalled,
// and bubbles in the pipeline are filled even while the output stalls. The divisions by
// the channel spread and by the saturation denominator use a 256-entry reciprocal table,
// a 24x24 (hue) or 22x24 (saturation) multiply stage, a remainder stage and a single-step correction.
module rgb_to_hsl_converter
  import rgb2hsl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CH_W-1:0]  in_red,
  input  wire logic [CH_W-1:0]  in_green,
  input  wire logic [CH_W-1:0]  in_blue,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [HUE_W-1:0]      out_hue,
  output logic [PCT_W-1:0]      out_saturation,
  output logic [PCT_W-1:0]      out_lightness
);

  // reciprocal table, floor(2^23 / x)
  logic [RCP_W-1:0] rcp_lut [RCP_DEPTH];

  for (genvar i = 0; i < RCP_DEPTH; i++) begin : g_rcp
    localparam int unsigned RCP_VAL =
      (i == 0) ? 0 : (32'd1 << (RCP_SHIFT - 1)) / ((i == 0) ? 1 : i);
    assign rcp_lut[i] = RCP_W'(RCP_VAL);
  end

  // stage enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || !out_stall;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // stage 1: max, min, spread, hue numerator in spread units
  logic [CH_W-1:0]   mx, mn, d_nxt, sden_nxt;
  logic [SUM_W-1:0]  sum_nxt;
  logic [HNUM_W-1:0] hnum_nxt;

  always_comb begin
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    d_nxt   = mx - mn;
    sum_nxt = SUM_W'(mx) + SUM_W'(mn);
    if (sum_nxt <= SUM_W'(255)) begin
      sden_nxt = sum_nxt[CH_W-1:0];
    end else begin
      sden_nxt = CH_W'(SUM_W'(510) - sum_nxt);
    end
    if (mx == in_red) begin
      if (in_green >= in_blue) begin
        hnum_nxt = HNUM_W'(in_green - in_blue);
      end else begin
        hnum_nxt = HNUM_W'(6) * HNUM_W'(d_nxt) - HNUM_W'(in_blue - in_green);
      end
    end else if (mx == in_green) begin
      hnum_nxt = (HNUM_W'(d_nxt) << 1) + HNUM_W'(in_blue) - HNUM_W'(in_red);
    end else begin
      hnum_nxt = (HNUM_W'(d_nxt) << 2) + HNUM_W'(in_red) - HNUM_W'(in_green);
    end
  end

  logic [CH_W-1:0]   d1_r, sden1_r;
  logic [SUM_W-1:0]  sum1_r;
  logic [HNUM_W-1:0] hnum1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_r    <= d_nxt;
      sden1_r <= sden_nxt;
      sum1_r  <= sum_nxt;
      hnum1_r <= hnum_nxt;
    end
  end

  // stage 2: rounding numerators and reciprocals
  logic [NH_W-1:0]  nh_nxt;
  logic [NS_W-1:0]  ns_nxt;
  logic [NL_W-1:0]  nl_nxt;

  assign nh_nxt = NH_W'(hnum1_r) * NH_W'(HUE_SCALE2) + NH_W'(d1_r);
  assign ns_nxt = NS_W'(d1_r) * NS_W'(PCT_SCALE2) + NS_W'(sden1_r);
  assign nl_nxt = NL_W'(sum1_r) * NL_W'(PCT_SCALE2) + NL_W'(LIT_HALF);

  logic [NH_W-1:0]   nh2_r;
  logic [NS_W-1:0]   ns2_r;
  logic [NL_W-1:0]   nl2_r;
  logic [RCP_W-1:0]  rh2_r, rs2_r;
  logic [DEN2_W-1:0] dh2_2_r, ds2_2_r;
  logic              grey2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      nh2_r   <= nh_nxt;
      ns2_r   <= ns_nxt;
      nl2_r   <= nl_nxt;
      rh2_r   <= rcp_lut[d1_r];
      rs2_r   <= rcp_lut[sden1_r];
      dh2_2_r <= {d1_r, 1'b0};
      ds2_2_r <= {sden1_r, 1'b0};
      grey2_r <= (d1_r == '0);
    end
  end

  // stage 3: quotient estimates, at most one below the true quotient
  logic [NH_W+RCP_W-1:0]      ph;
  logic [NS_W+RCP_W-1:0]      ps;
  logic [NL_W+LIT_RCP_W-1:0]  pl;

  assign ph = (NH_W+RCP_W)'(nh2_r) * (NH_W+RCP_W)'(rh2_r);
  assign ps = (NS_W+RCP_W)'(ns2_r) * (NS_W+RCP_W)'(rs2_r);
  assign pl = (NL_W+LIT_RCP_W)'(nl2_r) * (NL_W+LIT_RCP_W)'(LIT_RCP);

  logic [HUE_W-1:0]  qh3_r;
  logic [PCT_W-1:0]  qs3_r, ql3_r;
  logic [NH_W-1:0]   nh3_r;
  logic [NS_W-1:0]   ns3_r;
  logic [NL_W-1:0]   nl3_r;
  logic [DEN2_W-1:0] dh2_3_r, ds2_3_r;
  logic              grey3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      qh3_r   <= ph[RCP_SHIFT +: HUE_W];
      qs3_r   <= ps[RCP_SHIFT +: PCT_W];
      ql3_r   <= pl[RCP_SHIFT +: PCT_W];
      nh3_r   <= nh2_r;
      ns3_r   <= ns2_r;
      nl3_r   <= nl2_r;
      dh2_3_r <= dh2_2_r;
      ds2_3_r <= ds2_2_r;
      grey3_r <= grey2_r;
    end
  end

  // stage 4: remainders
  logic [NH_W-1:0] diff_h;
  logic [NS_W-1:0] diff_s;
  logic [NL_W-1:0] diff_l;

  assign diff_h = nh3_r - NH_W'(qh3_r) * NH_W'(dh2_3_r);
  assign diff_s = ns3_r - NS_W'(qs3_r) * NS_W'(ds2_3_r);
  assign diff_l = nl3_r - NL_W'(ql3_r) * NL_W'(LIT_DEN2);

  logic [HUE_W-1:0]  qh4_r;
  logic [PCT_W-1:0]  qs4_r, ql4_r;
  logic [DEN2_W:0]   remh4_r, rems4_r;
  logic [10:0]       reml4_r;
  logic [DEN2_W-1:0] dh2_4_r, ds2_4_r;
  logic              grey4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      qh4_r   <= qh3_r;
      qs4_r   <= qs3_r;
      ql4_r   <= ql3_r;
      remh4_r <= diff_h[DEN2_W:0];
      rems4_r <= diff_s[DEN2_W:0];
      reml4_r <= diff_l[10:0];
      dh2_4_r <= dh2_3_r;
      ds2_4_r <= ds2_3_r;
      grey4_r <= grey3_r;
    end
  end

  // stage 5: correction step and result register
  logic [HUE_W-1:0] hue_nxt;
  logic [PCT_W-1:0] sat_nxt, lit_nxt;

  always_comb begin
    hue_nxt = qh4_r + HUE_W'(remh4_r >= (DEN2_W+1)'(dh2_4_r));
    sat_nxt = qs4_r + PCT_W'(rems4_r >= (DEN2_W+1)'(ds2_4_r));
    lit_nxt = ql4_r + PCT_W'(reml4_r >= LIT_DEN2);
    if (grey4_r) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end
  end

  logic [HUE_W-1:0] hue_r;
  logic [PCT_W-1:0] sat_r, lit_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      lit_r <= lit_nxt;
    end
  end

  assign out_valid      = v5_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_lightness  = lit_r;

`ifndef SYNTHESIS
  // reciprocal estimate is never more than one short
  a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !grey3_r |-> diff_h < 2 * NH_W'(dh2_3_r))
    else $error("hue remainder out of range");

  a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !grey3_r |-> diff_s < 2 * NS_W'(ds2_3_r))
    else $error("saturation remainder out of range");

  a_lit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> diff_l < 2 * NL_W'(LIT_DEN2))
    else $error("lightness remainder out of range");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < HUE_LIMIT && out_saturation <= PCT_MAX &&
                  out_lightness <= PCT_MAX)
    else $error("result out of range");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> !in_stall)
    else $error("input stalled with empty first stage");
`endif

endmodule

`default_nettype wire

// ----- tb/rgb_to_hsl_converter_test.sv -----
// self-checking bench for rgb_to_hsl_converter: directed table, then random pixels
// depends on rgb2hsl_pkg and the rgb_to_hsl_converter rtl
`timescale 1ns / 1ps

module rgb_to_hsl_converter_test;
  import rgb2hsl_pkg::*;

  localparam int unsigned HUE_STEP   = 3840;
  localparam int unsigned PCT_FULL   = 6400;
  localparam int unsigned RAND_BEATS = 550;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned DIR_ROWS_N = 22;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] lit;
  } hsl_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic            typed;
    hsl_t            want;
  } pixel_row_t;

  // black, white, primaries and secondaries carry their result inline
  localparam pixel_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     13'd0,    13'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     13'd0,    13'd6400}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     13'd6400, 13'd3200}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  13'd6400, 13'd3200}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 13'd6400, 13'd3200}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  13'd6400, 13'd3200}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 13'd6400, 13'd3200}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 13'd6400, 13'd3200}},
    '{8'd128, 8'd128, 8'd128, 1'b0, '0},
    '{8'd1,   8'd1,   8'd1,   1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd255, 8'd255, 8'd254, 1'b0, '0},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd200, 8'd50,  8'd50,  1'b0, '0},
    '{8'd10,  8'd200, 8'd200, 1'b0, '0},
    '{8'd100, 8'd100, 8'd50,  1'b0, '0},
    '{8'd200, 8'd55,  8'd100, 1'b0, '0},
    '{8'd200, 8'd56,  8'd100, 1'b0, '0},
    '{8'd255, 8'd128, 8'd0,   1'b0, '0},
    '{8'd37,  8'd201, 8'd99,  1'b0, '0},
    '{8'd170, 8'd85,  8'd170, 1'b0, '0},
    '{8'd85,  8'd170, 8'd85,  1'b0, '0}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CH_W-1:0]  in_red = '0;
  logic [CH_W-1:0]  in_green = '0;
  logic [CH_W-1:0]  in_blue = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [HUE_W-1:0] out_hue;
  logic [PCT_W-1:0] out_saturation;
  logic [PCT_W-1:0] out_lightness;

  hsl_t        hsl_expected_q [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned pixels_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_hold = 0;
  bit          sink_calm = 1'b0;
  bit          src_calm = 1'b0;
  bit          beat_taken = 1'b0;

  rgb_to_hsl_converter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_lightness  (out_lightness)
  );

  always #5 clk = ~clk;

  function automatic int unsigned round_div(int unsigned num, int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic hsl_t predict_hsl(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                       logic [CH_W-1:0] b);
    int unsigned top;
    int unsigned low;
    int unsigned spread;
    int unsigned total;
    int unsigned sden;
    int unsigned hnum;
    hsl_t res;
    top = r;
    low = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < low) low = g;
    if (b < low) low = b;
    spread = top - low;
    total = top + low;
    res = '0;
    res.lit = PCT_W'(round_div(total * PCT_FULL, 510));
    if (spread != 0) begin
      sden = (total <= 255) ? total : 510 - total;
      res.sat = PCT_W'(round_div(spread * PCT_FULL, sden));
      // red wins ties, then green
      if (top == r) begin
        hnum = (g >= b) ? g - b : 6 * spread - (b - g);
      end else if (top == g) begin
        hnum = 2 * spread + b - r;
      end else begin
        hnum = 4 * spread + r - g;
      end
      res.hue = HUE_W'(round_div(hnum * HUE_STEP, spread));
    end
    return res;
  endfunction

  function automatic logic [CH_W-1:0] clamp_ch(int v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return CH_W'(v);
  endfunction

  // entered and left at a falling edge
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b, input hsl_t want);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hsl_expected_q.push_back(want);
    pixels_sent++;
    @(negedge clk);
  endtask

  // result side
  always @(posedge clk) begin
    hsl_t want;
    if (rst_n && out_valid && !out_stall) begin
      beat_taken = 1'b1;
      results_seen++;
      if (hsl_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: hue %0d sat %0d lit %0d",
                   out_hue, out_saturation, out_lightness);
      end else begin
        want = hsl_expected_q.pop_front();
        if (out_hue !== want.hue || out_saturation !== want.sat ||
            out_lightness !== want.lit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: expected hue %0d sat %0d lit %0d, got hue %0d sat %0d lit %0d",
                     results_seen, want.hue, want.sat, want.lit,
                     out_hue, out_saturation, out_lightness);
        end
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
    if (beat_taken) begin
      beat_taken = 1'b0;
      sink_hold = sink_calm ? 0 : $urandom_range(0, 12);
    end
    if (sink_hold != 0) begin
      out_stall <= 1'b1;
      sink_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycle_count, hsl_expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    int v;
    pixel_row_t row;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      send_pixel(row.r, row.g, row.b,
                 row.typed ? row.want : predict_hsl(row.r, row.g, row.b));
    end

    for (int n = 0; n < RAND_BEATS; n++) begin
      if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
      r = CH_W'($urandom_range(0, 255));
      g = CH_W'($urandom_range(0, 255));
      b = CH_W'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        4: begin
          g = r;
          b = r;
        end
        5: begin
          v = int'(r);
          g = clamp_ch(v + int'($urandom_range(0, 6)) - 3);
          b = clamp_ch(v + int'($urandom_range(0, 6)) - 3);
        end
        6: begin
          r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          g = $urandom_range(0, 1) ? 8'd255 : g;
          b = $urandom_range(0, 1) ? 8'd0 : b;
        end
        7: begin
          case ($urandom_range(0, 2))
            0: g = r;
            1: b = g;
            default: b = r;
          endcase
        end
        8: begin
          r = r & 8'h0f;
          g = g & 8'h0f;
          b = b & 8'h0f;
        end
        9: begin
          r = r | 8'hf0;
          g = g | 8'hf0;
          b = b | 8'hf0;
        end
        default: ;
      endcase
      send_pixel(r, g, b, predict_hsl(r, g, b));
    end
    in_valid <= 1'b0;

    while (hsl_expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (hsl_expected_q.size() != 0) mismatches++;

    $display("converted %0d pixels (%0d table rows, %0d random), %0d results checked",
             pixels_sent, DIR_ROWS_N, RAND_BEATS, results_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
